// ===== rtl/core/dual_stack_shared_array_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual stack block
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_ARRAY_ASSERT_SVH
`define DUAL_STACK_SHARED_ARRAY_ASSERT_SVH

`ifndef SYNTH
// check with reset disable
`define DSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds during reset
`define DSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSS_ASSERT(label, clk, rst, prop, msg)
`define DSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, command and status codes for the dual stack block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-request result, apart from the memory read data
  typedef struct packed {
    status_t status;
    logic    is_empty;
    logic    has_data;
  } res_t;

endpackage

// ===== rtl/core/dss_if.sv =====
// ----------------------------------------------------------------------------
// dss_req_if / dss_rsp_if
// Valid/ready channels for requests and responses of the dual stack block.
// ----------------------------------------------------------------------------
interface dss_req_if
  import dss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic                     which_stack;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, which_stack, value, input ready);
  modport sink   (input valid, command, which_stack, value, output ready);
endinterface

interface dss_rsp_if
  import dss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic                     is_empty;

  modport source (output valid, status, data, is_empty, input ready);
  modport sink   (input valid, status, data, is_empty, output ready);
endinterface

// ===== rtl/core/dss_mem.sv =====
// ----------------------------------------------------------------------------
// dss_mem
// Single-port synchronous RAM holding both stacks, registered read data.
// ----------------------------------------------------------------------------
module dss_mem
  import dss_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [DATA_W-1:0]          wdata,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Depth counters, capacity register, addressing and request decode.
// ----------------------------------------------------------------------------
module dss_ctrl
  import dss_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CAP_W-1:0]           cfg_wdata,
  input  logic                       acc,
  input  cmd_t                       command,
  input  logic                       which_stack,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [$clog2(DEPTH)-1:0]   mem_addr,
  output res_t                       res
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam int CW = (DW > CAP_W) ? DW : CAP_W;
  localparam int SW = CW + 1;

  logic [CAP_W-1:0] capacity;
  logic [DW-1:0]    low_depth, low_depth_next;
  logic [DW-1:0]    high_depth, high_depth_next;

  logic [CW-1:0]        cap_ext, eff_cap;
  logic [SW-1:0]        total;
  logic                 full;
  logic [DW-1:0]        sel_depth, sel_depth_next;
  logic                 sel_zero;
  logic [DW:0]          minus;
  logic signed [SW:0]   hdiff, hfix;
  logic [AW-1:0]        low_addr, high_addr;
  logic                 is_push;

  assign cap_ext = CW'(capacity);
  assign eff_cap = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
  assign total   = SW'(low_depth) + SW'(high_depth);
  assign full    = total >= SW'(eff_cap);

  assign sel_depth = which_stack ? high_depth : low_depth;
  assign sel_zero  = (sel_depth == '0);
  assign is_push   = (command == CMD_PUSH);

  // stack one: push at cap-1-depth, top at cap-depth, wrapped into range
  assign minus = is_push ? ((DW+1)'(high_depth) + 1'b1) : (DW+1)'(high_depth);
  assign hdiff = $signed((SW+1)'(eff_cap)) - $signed((SW+1)'(minus));
  always_comb begin
    hfix = hdiff;
    if (hdiff < 0) begin
      hfix = hdiff + $signed((SW+1)'(DEPTH));
    end else if (hdiff >= $signed((SW+1)'(DEPTH))) begin
      hfix = hdiff - $signed((SW+1)'(DEPTH));
    end
  end
  assign high_addr = hfix[AW-1:0];
  assign low_addr  = is_push ? low_depth[AW-1:0] : AW'(low_depth - 1'b1);
  assign mem_addr  = which_stack ? high_addr : low_addr;

  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    sel_depth_next = sel_depth;
    res.status     = ST_DONE;
    res.has_data   = 1'b0;
    unique case (command)
      CMD_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          mem_we         = acc;
          sel_depth_next = sel_depth + 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (sel_zero) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re       = acc;
          res.has_data = 1'b1;
          if (command == CMD_POP) begin
            sel_depth_next = sel_depth - 1'b1;
          end
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
    res.is_empty = (sel_depth_next == '0);
  end

  always_comb begin
    low_depth_next  = low_depth;
    high_depth_next = high_depth;
    if (which_stack) begin
      high_depth_next = sel_depth_next;
    end else begin
      low_depth_next = sel_depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      low_depth  <= '0;
      high_depth <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (acc) begin
        low_depth  <= low_depth_next;
        high_depth <= high_depth_next;
      end
    end
  end

endmodule

// ===== rtl/core/dual_stack_shared_array.sv =====
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// Two LIFO stacks sharing one RAM; stack zero grows up, stack one down.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries command (push, pop, peek, query empty), which_stack
//   and the value to push. rsp channel returns status (done, full, empty),
//   the popped or peeked word (zero otherwise) and is_empty of the selected
//   stack after the request.
//   cfg_we/cfg_wdata write the capacity; write it only while idle.
//   Capacities above DEPTH act as DEPTH.
// Timing:
//   One request per cycle sustained while rsp.ready stays high. The response
//   appears in the cycle after the request is taken, set by the RAM's registered read.
//   Depth counters update when the request is taken, so the next request
//   sees them at once; pushes and pops to the same entry never collide.
// Reset:
//   Both stacks empty, capacity 1024. RAM contents are not cleared.
// Stall:
//   While a response waits on rsp.ready, req.ready stays low unless that
//   response is taken in the same cycle.
// ----------------------------------------------------------------------------
module dual_stack_shared_array
  import dss_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  dss_req_if.sink           req,
  dss_rsp_if.source         rsp
);

  `include "dual_stack_shared_array_assert.svh"

  logic                      acc;
  logic                      mem_we, mem_re;
  logic [$clog2(DEPTH)-1:0]  mem_addr;
  logic [DATA_W-1:0]         rdata;
  res_t                      res;
  res_t                      res_q;
  logic                      pend_valid;

  assign req.ready = !pend_valid || rsp.ready;
  assign acc       = req.valid && req.ready;

  dss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .command     (cmd_t'(req.command)),
    .which_stack (req.which_stack),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .res         (res)
  );

  dss_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (req.value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (acc) begin
      pend_valid <= 1'b1;
    end else if (rsp.ready) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res;
    end
  end

  // rdata only changes on a taken pop/peek, so it holds through a stall
  assign rsp.valid    = pend_valid;
  assign rsp.status   = res_q.status;
  assign rsp.is_empty = res_q.is_empty;
  assign rsp.data     = res_q.has_data ? $signed(rdata) : '0;

  `DSS_ASSERT(a_rsp_follows_req, clk, rst, (req.valid && req.ready) |=> rsp.valid, "no response after request")
  `DSS_ASSERT(a_stall_blocks_req, clk, rst, (rsp.valid && !rsp.ready) |-> !req.ready, "request taken while response stalled")
  `DSS_ASSERT(a_no_data_on_fail, clk, rst, (rsp.valid && rsp.status != ST_DONE) |-> (rsp.data == '0), "data on refused or empty response")
  `DSS_ASSERT_ALWAYS(a_mem_one_access, clk, !(mem_we && mem_re), "RAM read and write in one cycle")

endmodule

// ===== test/dss_stack_checker.sv =====
// ----------------------------------------------------------------------------
// dss_stack_checker
// Watches the request, response and capacity ports of the dual stack block,
// keeps its own copy of both stacks and compares every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dss_stack_checker
  import dss_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  dss_req_if               req,
  dss_rsp_if               rsp,
  output int               mismatches,
  output int               pending,
  output int               low_fill,
  output int               high_fill
);

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     is_empty;
  } stack_answer_t;

  stack_answer_t     answer_q[$];
  logic [DATA_W-1:0] mirror_mem [DEPTH];
  int unsigned       lo_d;
  int unsigned       hi_d;
  logic [CAP_W-1:0]  cap_q;
  int                errs;

  // Advances the mirrored stacks by one request and returns its response.
  function automatic stack_answer_t apply_stack_cmd(cmd_t cmd, logic sel,
                                                    logic [DATA_W-1:0] val);
    stack_answer_t a;
    int unsigned   eff;
    int unsigned   d;
    eff      = (cap_q > DEPTH) ? DEPTH : cap_q;
    a.status = ST_DONE;
    a.data   = '0;
    case (cmd)
      CMD_PUSH: begin
        if (lo_d + hi_d >= eff) begin
          a.status = ST_FULL;
        end else if (!sel) begin
          mirror_mem[lo_d % DEPTH] = val;
          lo_d++;
        end else begin
          mirror_mem[(eff + 2 * DEPTH - hi_d - 1) % DEPTH] = val;
          hi_d++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        d = sel ? hi_d : lo_d;
        if (d == 0) begin
          a.status = ST_EMPTY;
        end else begin
          if (sel) begin
            a.data = mirror_mem[(eff + 2 * DEPTH - hi_d) % DEPTH];
          end else begin
            a.data = mirror_mem[(lo_d - 1) % DEPTH];
          end
          if (cmd == CMD_POP) begin
            if (sel) hi_d--;
            else     lo_d--;
          end
        end
      end
      default: ;
    endcase
    a.is_empty = ((sel ? hi_d : lo_d) == 0);
    return a;
  endfunction

  always @(posedge clk) begin
    stack_answer_t e;
    if (rst) begin
      lo_d  = 0;
      hi_d  = 0;
      cap_q = CAP_RESET;
      errs  = 0;
      answer_q.delete();
    end else begin
      // predict first so a response in the same cycle as its request would still find its entry
      if (req.valid && req.ready)
        answer_q.push_back(apply_stack_cmd(cmd_t'(req.command), req.which_stack,
                                           req.value));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected response status=%0d data=%h is_empty=%b",
                   $time, rsp.status, rsp.data, rsp.is_empty);
        end else begin
          e = answer_q.pop_front();
          if (rsp.status !== e.status) begin
            errs++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          end
          if (rsp.data !== e.data) begin
            errs++;
            $display("%0t: data expected %h actual %h", $time, e.data, rsp.data);
          end
          if (rsp.is_empty !== e.is_empty) begin
            errs++;
            $display("%0t: is_empty expected %b actual %b", $time, e.is_empty,
                     rsp.is_empty);
          end
        end
      end
      if (cfg_we) cap_q = cfg_wdata;
    end
    mismatches <= errs;
    pending    <= answer_q.size();
    low_fill   <= lo_d;
    high_fill  <= hi_d;
  end

endmodule

// ===== test/tb_dual_stack_shared_array.sv =====
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_array
// Directed and random requests to both stacks across a range of capacities,
// with idle and stall phases on both channels; the checker scores responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_stack_shared_array;
  import dss_pkg::*;

  localparam int DEPTH = 1024;

  typedef enum int {
    IDLE_NONE   = 0,
    IDLE_SENDER = 1,
    IDLE_RECV   = 2,
    IDLE_BOTH   = 3
  } idle_mode_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  idle_mode_t       idle_mode;
  int               mismatches;
  int               pending;
  int               low_fill;
  int               high_fill;

  dss_req_if req_if ();
  dss_rsp_if rsp_if ();

  dual_stack_shared_array #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  dss_stack_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if),
    .mismatches(mismatches),
    .pending   (pending),
    .low_fill  (low_fill),
    .high_fill (high_fill)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int idle_pct(idle_mode_t m, bit sender);
    if (m == IDLE_BOTH) return 9;
    if (sender) return (m == IDLE_SENDER) ? 57 : 0;
    return (m == IDLE_RECV) ? 57 : 0;
  endfunction

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b0));
    end
  end

  task automatic send_req(cmd_t cmd, logic sel, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct(idle_mode, 1'b1)) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= cmd;
    req_if.which_stack <= sel;
    req_if.value       <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Empty stack one, and stack zero too if also_low, so a capacity change never moves stack one's entries.
  task automatic drain_stacks(bit also_low);
    int n_hi;
    int n_lo;
    wait_drained();
    n_hi = high_fill;
    n_lo = low_fill;
    repeat (n_hi) send_req(CMD_POP, 1'b1, pick_value());
    if (also_low) repeat (n_lo) send_req(CMD_POP, 1'b0, pick_value());
    wait_drained();
  endtask

  task automatic random_req(int push_pct, int s0_pct);
    cmd_t cmd;
    int   r;
    if ($urandom_range(99) < push_pct) begin
      cmd = CMD_PUSH;
    end else begin
      r = $urandom_range(9);
      cmd = (r < 5) ? CMD_POP : (r < 8) ? CMD_PEEK : CMD_QUERY;
    end
    send_req(cmd, ($urandom_range(99) >= s0_pct), pick_value());
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int n, int push_pct, int s0_pct,
                           bit keep_low, idle_mode_t mode);
    drain_stacks(!keep_low);
    write_capacity(cap);
    idle_mode <= mode;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      random_req(push_pct, s0_pct);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    idle_mode          <= IDLE_NONE;
    req_if.valid       <= 1'b0;
    req_if.command     <= CMD_PUSH;
    req_if.which_stack <= 1'b0;
    req_if.value       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty answers, extreme words, both stacks, reset capacity
    send_req(CMD_QUERY, 1'b0, '0);
    send_req(CMD_QUERY, 1'b1, '1);
    send_req(CMD_POP,   1'b0, '0);
    send_req(CMD_PEEK,  1'b1, '0);
    send_req(CMD_PUSH,  1'b0, 32'h7fff_ffff);
    send_req(CMD_PUSH,  1'b1, 32'h8000_0000);
    send_req(CMD_PUSH,  1'b0, '0);
    send_req(CMD_PUSH,  1'b1, '1);
    send_req(CMD_PEEK,  1'b0, '0);
    send_req(CMD_PEEK,  1'b1, '0);
    send_req(CMD_QUERY, 1'b0, '0);
    send_req(CMD_POP,   1'b0, '0);
    send_req(CMD_POP,   1'b0, '0);
    send_req(CMD_POP,   1'b1, '0);
    send_req(CMD_POP,   1'b1, '0);
    send_req(CMD_POP,   1'b0, '0);

    // one-entry capacity: the other stack is refused
    write_capacity(11'd1);
    send_req(CMD_PUSH,  1'b1, 32'h1234_5678);
    send_req(CMD_PUSH,  1'b0, 32'h0bad_cafe);
    send_req(CMD_POP,   1'b1, '0);
    send_req(CMD_PUSH,  1'b0, 32'h8000_0001);
    send_req(CMD_PUSH,  1'b1, 32'h7fff_fffe);
    send_req(CMD_POP,   1'b0, '0);

    // zero capacity refuses every push
    write_capacity(11'd0);
    send_req(CMD_PUSH,  1'b0, '1);
    send_req(CMD_PUSH,  1'b1, '1);
    send_req(CMD_QUERY, 1'b1, '0);

    run_phase(11'd6,    200, 55, 50, 1'b0, IDLE_NONE);
    run_phase(11'd3,    150, 55, 50, 1'b1, IDLE_SENDER);
    run_phase(11'd1,     80, 50, 50, 1'b0, IDLE_RECV);
    run_phase(11'd0,     40, 50, 50, 1'b0, IDLE_BOTH);
    run_phase(11'd2047, 150, 70, 50, 1'b0, IDLE_NONE);
    run_phase(11'd1500, 150, 40, 50, 1'b1, IDLE_SENDER);
    run_phase(11'd1024, 200, 45, 50, 1'b0, IDLE_RECV);
    run_phase(11'd16,   250, 60, 40, 1'b0, IDLE_BOTH);
    run_phase(11'd1023, 150, 50, 50, 1'b1, IDLE_RECV);
    run_phase(11'd2,    150, 55, 50, 1'b0, IDLE_SENDER);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dss_pkg.sv
rtl/core/dss_if.sv
rtl/core/dss_mem.sv
rtl/core/dss_ctrl.sv
rtl/core/dual_stack_shared_array.sv
test/dss_stack_checker.sv
test/tb_dual_stack_shared_array.sv
